// ----- hdl/bfa_pkg.sv -----
// Shared types and constants for the bitmap frame allocator.
package bfa_pkg;

	localparam int WORD_BITS      = 32;
	localparam int BIT_W          = $clog2(WORD_BITS);
	localparam int ADDR_W         = 32;
	localparam int CNT_W          = 13;
	localparam int BLOCK_BYTES    = 4096;
	localparam int BLOCK_SHIFT    = $clog2(BLOCK_BYTES);
	localparam int NUM_BLOCKS_DEF = 4096;

	localparam logic [CNT_W-1:0] LIMIT_RST = CNT_W'(4096);

	typedef enum logic [1:0] {
		FN_ALLOC  = 2'd0,
		FN_FREE   = 2'd1,
		FN_MARK   = 2'd2,
		FN_UNMARK = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP,
		ST_ROUND,
		ST_CLIP,
		ST_ALLOC_RD,
		ST_ALLOC_CHK,
		ST_ALLOC_HIT,
		ST_SPAN_INIT,
		ST_SPAN_RD,
		ST_SPAN_WR,
		ST_COUNT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
	} map_ctl_t;

	typedef struct packed {
		logic bit_val;
		logic all_ones;
		logic all_zero;
	} word_info_t;

endpackage

// ----- hdl/bfa_bitmap.sv -----
// Usage bitmap storage: one write port and one registered read port.
module bfa_bitmap #(
	parameter int WORDS = 128,
	parameter int IDX_W = 7
) (
	input  logic                          clk,
	input  bfa_pkg::map_ctl_t             ctl,
	input  logic [IDX_W-1:0]              wr_idx,
	input  logic [bfa_pkg::WORD_BITS-1:0] wr_data,
	input  logic [IDX_W-1:0]              rd_idx,
	output logic [bfa_pkg::WORD_BITS-1:0] rd_data
);
	import bfa_pkg::*;

	logic [WORD_BITS-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data <= mem[rd_idx];
		end
	end

endmodule

// ----- hdl/bfa_word_unit.sv -----
// Shared word unit: bit pick, all-free and all-used tests, and masked set or clear.
module bfa_word_unit (
	input  logic [bfa_pkg::WORD_BITS-1:0] data,
	input  logic [bfa_pkg::BIT_W-1:0]     offset,
	input  logic [bfa_pkg::BIT_W-1:0]     lo,
	input  logic [bfa_pkg::BIT_W-1:0]     hi,
	input  logic                          set,
	output bfa_pkg::word_info_t           info,
	output logic [bfa_pkg::WORD_BITS-1:0] merged
);
	import bfa_pkg::*;

	localparam logic [BIT_W-1:0] TOP_BIT = BIT_W'(WORD_BITS - 1);

	logic [WORD_BITS-1:0] mask;

	always_comb begin
		info.bit_val  = data[offset];
		info.all_ones = &data;
		info.all_zero = ~|data;
		mask = ({WORD_BITS{1'b1}} << lo) & ({WORD_BITS{1'b1}} >> (TOP_BIT - hi));
		merged = set ? (data | mask) : (data & ~mask);
	end

endmodule

// ----- hdl/bfa_core.sv -----
// Allocator sequencer: first-fit scan, span update over the bitmap and used-block count.
module bfa_core #(
	parameter int NUM_BLOCKS = bfa_pkg::NUM_BLOCKS_DEF,
	localparam int MAP_WORDS = (NUM_BLOCKS + bfa_pkg::WORD_BITS - 1) / bfa_pkg::WORD_BITS,
	localparam int IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_take,
	input  logic [1:0]                    req_func,
	input  logic [bfa_pkg::ADDR_W-1:0]    req_address,
	input  logic [bfa_pkg::ADDR_W-1:0]    req_amount,
	input  logic                          cfg_wr,
	input  logic [bfa_pkg::CNT_W-1:0]     cfg_max_blocks,
	output logic                          busy,
	output logic                          res_valid,
	input  logic                          res_take,
	output logic                          res_ok,
	output logic [bfa_pkg::ADDR_W-1:0]    res_block_address,
	output logic [bfa_pkg::CNT_W-1:0]     res_used_count,
	output bfa_pkg::map_ctl_t             map_ctl,
	output logic [IDX_W-1:0]              map_rd_idx,
	output logic [IDX_W-1:0]              map_wr_idx,
	output logic [bfa_pkg::WORD_BITS-1:0] map_wr_data,
	input  logic [bfa_pkg::WORD_BITS-1:0] map_rd_data
);
	import bfa_pkg::*;

	localparam int BW    = $clog2(NUM_BLOCKS + 1);
	localparam int CW    = ((BW > CNT_W) ? BW : CNT_W) + 1;
	localparam int SUM_W = ADDR_W + 1;
	localparam int HI_B  = IDX_W + BIT_W - 1;
	localparam logic [CNT_W-1:0] NB_CAP = (NUM_BLOCKS > (2 ** CNT_W - 1)) ?
		CNT_W'(2 ** CNT_W - 1) : CNT_W'(NUM_BLOCKS);
	localparam logic [CNT_W-1:0] LIM_RST = (NB_CAP < LIMIT_RST) ? NB_CAP : LIMIT_RST;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAP_WORDS - 1);
	localparam logic [SUM_W-1:0] NB_SUM = SUM_W'(NUM_BLOCKS);
	localparam logic [BW-1:0]    NB_B   = BW'(NUM_BLOCKS);

	state_t state_q, state_d;

	func_t                func_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [ADDR_W-1:0]    amt_q;
	logic [SUM_W-1:0]     acc_q;
	logic [SUM_W-1:0]     n_q;
	logic [CNT_W-1:0]     lim_q;
	logic [CNT_W-1:0]     used_q;
	logic [IDX_W-1:0]     clr_idx_q;
	logic [BW-1:0]        b_q;
	logic [CNT_W-1:0]     run_q;
	logic [BW-1:0]        first_q;
	logic [BW-1:0]        span_first_q;
	logic [BW-1:0]        span_last_q;
	logic [BW-1:0]        lastm1_q;
	logic [IDX_W-1:0]     w_q;
	logic                 set_q;
	logic                 ok_q;
	logic [ADDR_W-1:0]    baddr_q;

	logic [SUM_W-1:0]     page;
	logic [CNT_W-1:0]     free_cnt;
	logic                 amt_bad;
	logic [CW-1:0]        lim_c;
	logic                 b_past_lim;
	logic [BW-1:0]        b_next;
	logic                 at_end;
	logic                 fast;
	logic                 fast_skip;
	logic                 fast_fill;
	logic                 run_fast;
	logic [CNT_W-1:0]     run_inc;
	logic                 hit_bit;
	logic [BW-1:0]        run_start;
	logic [BW-1:0]        last_clip;
	logic                 span_empty;
	logic                 last_word;
	logic [BIT_W-1:0]     lo;
	logic [BIT_W-1:0]     hi;
	word_info_t           info;
	logic [WORD_BITS-1:0] merged;
	logic [CNT_W:0]       add_sum;
	logic [CNT_W-1:0]     cnt_add;
	logic [CNT_W-1:0]     cnt_sub;
	logic [CNT_W-1:0]     lim_new;

	bfa_word_unit u_word (
		.data   (map_rd_data),
		.offset (b_q[BIT_W-1:0]),
		.lo     (lo),
		.hi     (hi),
		.set    (set_q),
		.info   (info),
		.merged (merged)
	);

	always_comb begin
		page       = SUM_W'(addr_q[ADDR_W-1:BLOCK_SHIFT]);
		free_cnt   = lim_q - used_q;
		amt_bad    = (amt_q == '0) || (amt_q > ADDR_W'(free_cnt));
		lim_c      = CW'(lim_q);
		b_past_lim = CW'(b_q) >= lim_c;
		b_next     = b_q + 1'b1;
		at_end     = CW'(b_next) >= lim_c;
		fast       = (b_q[BIT_W-1:0] == '0) && ((CW'(b_q) + CW'(WORD_BITS)) <= lim_c);
		fast_skip  = fast && info.all_ones;
		fast_fill  = fast && info.all_zero;
		run_fast   = ({1'b0, run_q} + (CNT_W + 1)'(WORD_BITS)) >= {1'b0, amt_q[CNT_W-1:0]};
		run_inc    = run_q + 1'b1;
		hit_bit    = run_inc == amt_q[CNT_W-1:0];
		run_start  = (run_q == '0) ? b_q : first_q;
		last_clip  = (acc_q > NB_SUM) ? NB_B : acc_q[BW-1:0];
		span_empty = (page >= acc_q) || (page >= NB_SUM);
		last_word  = w_q == lastm1_q[HI_B:BIT_W];
		lo = (w_q == span_first_q[HI_B:BIT_W]) ? span_first_q[BIT_W-1:0] : '0;
		hi = last_word ? lastm1_q[BIT_W-1:0] : '1;
		add_sum = {1'b0, used_q} + {1'b0, n_q[CNT_W-1:0]};
		if ((n_q[SUM_W-1:CNT_W] != '0) || (add_sum > {1'b0, lim_q})) begin
			cnt_add = lim_q;
		end else begin
			cnt_add = add_sum[CNT_W-1:0];
		end
		cnt_sub = (n_q >= SUM_W'(used_q)) ? '0 : (used_q - n_q[CNT_W-1:0]);
		lim_new = (cfg_max_blocks > NB_CAP) ? NB_CAP : cfg_max_blocks;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_idx_q == LAST_IDX) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (req_take) state_d = ST_SETUP;
			end
			ST_SETUP: begin
				if (func_q == FN_ALLOC) begin
					state_d = amt_bad ? ST_DONE : ST_ALLOC_RD;
				end else begin
					state_d = ST_ROUND;
				end
			end
			ST_ROUND: state_d = ST_CLIP;
			ST_CLIP: state_d = span_empty ? ST_COUNT : ST_SPAN_INIT;
			ST_ALLOC_RD: state_d = b_past_lim ? ST_DONE : ST_ALLOC_CHK;
			ST_ALLOC_CHK: begin
				if (fast_skip) begin
					state_d = ST_ALLOC_RD;
				end else if (fast_fill) begin
					state_d = run_fast ? ST_ALLOC_HIT : ST_ALLOC_RD;
				end else if (!info.bit_val && hit_bit) begin
					state_d = ST_ALLOC_HIT;
				end else if (at_end || (b_next[BIT_W-1:0] == '0)) begin
					state_d = ST_ALLOC_RD;
				end
			end
			ST_ALLOC_HIT: state_d = ST_SPAN_INIT;
			ST_SPAN_INIT: state_d = ST_SPAN_RD;
			ST_SPAN_RD: state_d = ST_SPAN_WR;
			ST_SPAN_WR: state_d = last_word ? ST_COUNT : ST_SPAN_RD;
			ST_COUNT: state_d = ST_DONE;
			ST_DONE: begin
				if (res_take) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		busy          = state_q != ST_IDLE;
		res_valid     = state_q == ST_DONE;
		map_ctl.rd_en = ((state_q == ST_ALLOC_RD) && !b_past_lim) || (state_q == ST_SPAN_RD);
		map_ctl.wr_en = (state_q == ST_CLEAR) || (state_q == ST_SPAN_WR);
		map_rd_idx    = (state_q == ST_ALLOC_RD) ? b_q[HI_B:BIT_W] : w_q;
		map_wr_idx    = (state_q == ST_CLEAR) ? clr_idx_q : w_q;
		map_wr_data   = (state_q == ST_CLEAR) ? {WORD_BITS{1'b1}} : merged;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
			lim_q     <= LIM_RST;
			used_q    <= LIM_RST;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_idx_q <= clr_idx_q + 1'b1;
			end
			if (cfg_wr) begin
				lim_q  <= lim_new;
				used_q <= (used_q > lim_new) ? lim_new : used_q;
			end else if (state_q == ST_COUNT) begin
				used_q <= set_q ? cnt_add : cnt_sub;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_take) begin
					func_q <= func_t'(req_func);
					addr_q <= req_address;
					amt_q  <= req_amount;
				end
			end
			ST_SETUP: begin
				set_q   <= (func_q == FN_ALLOC) || (func_q == FN_MARK);
				ok_q    <= func_q != FN_ALLOC;
				baddr_q <= '0;
				b_q     <= '0;
				run_q   <= '0;
				first_q <= '0;
				n_q     <= SUM_W'(amt_q);
				if (func_q == FN_FREE) begin
					acc_q <= page + SUM_W'(amt_q);
				end else begin
					acc_q <= SUM_W'(addr_q) + SUM_W'(amt_q);
				end
			end
			ST_ROUND: begin
				if (func_q != FN_FREE) begin
					acc_q <= SUM_W'(acc_q[SUM_W-1:BLOCK_SHIFT]) +
						SUM_W'(|acc_q[BLOCK_SHIFT-1:0]);
				end
			end
			ST_CLIP: begin
				if (func_q != FN_FREE) begin
					n_q <= acc_q - page;
				end
				span_first_q <= page[BW-1:0];
				span_last_q  <= last_clip;
			end
			ST_ALLOC_CHK: begin
				if (fast_skip) begin
					run_q <= '0;
					b_q   <= b_q + BW'(WORD_BITS);
				end else if (fast_fill) begin
					span_first_q <= run_start;
					first_q      <= run_start;
					run_q        <= run_q + CNT_W'(WORD_BITS);
					b_q          <= b_q + BW'(WORD_BITS);
				end else begin
					if (info.bit_val) begin
						run_q <= '0;
					end else begin
						first_q      <= run_start;
						span_first_q <= run_start;
						run_q        <= run_inc;
					end
					b_q <= b_next;
				end
			end
			ST_ALLOC_HIT: begin
				span_last_q <= span_first_q + amt_q[BW-1:0];
				ok_q        <= 1'b1;
				baddr_q     <= ADDR_W'(SUM_W'(span_first_q) << BLOCK_SHIFT);
			end
			ST_SPAN_INIT: begin
				lastm1_q <= span_last_q - 1'b1;
				w_q      <= span_first_q[HI_B:BIT_W];
			end
			ST_SPAN_WR: begin
				w_q <= w_q + 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res_ok            = ok_q;
	assign res_block_address = baddr_q;
	assign res_used_count    = used_q;

endmodule

// ----- hdl/bitmap_frame_allocator.sv -----
// Top level of the bitmap frame allocator: handshakes, result register and bitmap.
// After reset the bitmap is filled with ones, one word per cycle, 128 words by default;
// requests stall until then and configuration writes are taken. One request is in flight.
// Free, mark and unmark clip the span to the bitmap and rewrite each touched word. Allocate
// checks the size, then scans first fit: fully used words are skipped, fully free words taken
// whole, mixed words tested bit by bit; the run found is written and the used count updated.
module bitmap_frame_allocator #(
	parameter int NUM_BLOCKS = bfa_pkg::NUM_BLOCKS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic [1:0]                 func,
	input  logic [bfa_pkg::ADDR_W-1:0] address,
	input  logic [bfa_pkg::ADDR_W-1:0] amount,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic                       ok,
	output logic [bfa_pkg::ADDR_W-1:0] block_address,
	output logic [bfa_pkg::CNT_W-1:0]  used_count,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [bfa_pkg::CNT_W-1:0]  max_blocks
);
	import bfa_pkg::*;

	localparam int MAP_WORDS = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
	localparam int IDX_W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;

	map_ctl_t             map_ctl;
	logic [IDX_W-1:0]     map_rd_idx;
	logic [IDX_W-1:0]     map_wr_idx;
	logic [WORD_BITS-1:0] map_wr_data;
	logic [WORD_BITS-1:0] map_rd_data;
	logic                 busy;
	logic                 res_valid;
	logic                 res_take;
	logic                 res_ok;
	logic [ADDR_W-1:0]    res_block_address;
	logic [CNT_W-1:0]     res_used_count;
	logic                 rsp_valid_q;
	logic                 ok_q;
	logic [ADDR_W-1:0]    block_address_q;
	logic [CNT_W-1:0]     used_count_q;

	assign req_stall = busy;
	assign cfg_ready = 1'b1;
	assign res_take  = !rsp_valid_q || !rsp_stall;

	bfa_core #(
		.NUM_BLOCKS (NUM_BLOCKS)
	) u_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.req_take          (req_valid && !req_stall),
		.req_func          (func),
		.req_address       (address),
		.req_amount        (amount),
		.cfg_wr            (cfg_valid && cfg_ready),
		.cfg_max_blocks    (max_blocks),
		.busy              (busy),
		.res_valid         (res_valid),
		.res_take          (res_take),
		.res_ok            (res_ok),
		.res_block_address (res_block_address),
		.res_used_count    (res_used_count),
		.map_ctl           (map_ctl),
		.map_rd_idx        (map_rd_idx),
		.map_wr_idx        (map_wr_idx),
		.map_wr_data       (map_wr_data),
		.map_rd_data       (map_rd_data)
	);

	bfa_bitmap #(
		.WORDS (MAP_WORDS),
		.IDX_W (IDX_W)
	) u_bitmap (
		.clk     (clk),
		.ctl     (map_ctl),
		.wr_idx  (map_wr_idx),
		.wr_data (map_wr_data),
		.rd_idx  (map_rd_idx),
		.rd_data (map_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			ok_q            <= res_ok;
			block_address_q <= res_block_address;
			used_count_q    <= res_used_count;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign ok            = ok_q;
	assign block_address = block_address_q;
	assign used_count    = used_count_q;

endmodule

// ----- hdl/bfa_checker.sv -----
// Port-level checker for the bitmap frame allocator and its bind to the top level.
module bfa_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       req_valid,
	input logic                       req_stall,
	input logic                       rsp_valid,
	input logic                       rsp_stall,
	input logic                       ok,
	input logic [bfa_pkg::ADDR_W-1:0] block_address,
	input logic [bfa_pkg::CNT_W-1:0]  used_count
);
	import bfa_pkg::*;

	// A transaction on the request side makes the block busy on the next cycle.
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted but block not busy");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(ok) && $stable(block_address)
			&& $stable(used_count))
		else $error("stalled response changed");

	// A new result only appears while a request is being worked on.
	a_rsp_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid) |-> $past(req_stall))
		else $error("response without work in progress");

	a_fail_addr: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !ok |-> block_address == '0)
		else $error("failed allocation returned an address");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (.*);
